>>> sv/rsa_pkg.sv
// Shared types, codes and command/status structs of the rational sum accumulator.
package rsa_pkg;

    localparam int FIELD_W  = 32;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_DIV = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    typedef enum logic [1:0] {
        MUL_AD,
        MUL_BN,
        MUL_BD
    } mul_sel_t;

    typedef enum logic [1:0] {
        DIV_GCD,
        DIV_QN,
        DIV_QD
    } div_sel_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] numerator;
        logic signed [FIELD_W-1:0] denominator;
        logic                      last;
    } rsa_in_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] sum_numerator;
        logic signed [FIELD_W-1:0] sum_denominator;
        logic [STATUS_W-1:0]       status;
    } rsa_out_t;

    typedef struct packed {
        logic                load;
        logic                mul_en;
        mul_sel_t            mul_sel;
        logic                sum_en;
        logic                div_start;
        div_sel_t            div_sel;
        logic                gcd_step;
        logic                qn_en;
        logic                qd_en;
        logic                set_raw;
        logic                set_quot;
        logic                flag_en;
        logic [STATUS_W-1:0] flag_code;
        logic                emit;
    } rsa_cmd_t;

    typedef struct packed {
        logic prod_ovf;
        logic y_zero;
        logic g_zero;
        logic quot_ovf;
        logic div_busy;
        logic div_done;
        logic last;
    } rsa_sts_t;

endpackage

>>> sv/rsa_stream_if.sv
// Valid/ready stream interface used for the input and result channels.
interface rsa_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> sv/rational_sum_accumulator_unit.sv
// Top level of the rational sum accumulator: stream ports, controller and datapath.
//
// Adds a stream of signed fractions to a running sum that starts at 0/1 and reduces the
// sum after every addition by the Euclid divisor of its numerator and denominator; the
// fraction marked last delivers the sum with its sticky status and restarts the sum.
// One fraction is worked on at a time. Each Euclid remainder step (up to about 46 at 32
// bits) and both reduction divisions run on the single bit-serial divider; a fraction
// whose products overflow skips the Euclid loop and the divisions, and one whose raw
// sum is 0/0 skips the divisions. The next fraction is accepted while a result still
// waits to be transferred, but a fraction marked last holds in its finish state until
// the earlier result has been transferred.
module rational_sum_accumulator_unit
    import rsa_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input logic         clk,
    input logic         rst_n,
    rsa_stream_if.sink   fraction,
    rsa_stream_if.source result
);

    rsa_cmd_t cmd;
    rsa_sts_t sts;

    rsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (fraction.valid),
        .in_ready (fraction.ready),
        .out_valid(result.valid),
        .out_ready(result.ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    rsa_datapath #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .numerator      (fraction.data.numerator),
        .denominator    (fraction.data.denominator),
        .last           (fraction.data.last),
        .sum_numerator  (result.data.sum_numerator),
        .sum_denominator(result.data.sum_denominator),
        .status         (result.data.status)
    );

endmodule

>>> sv/rsa_divider.sv
// Bit-serial restoring divider for unsigned magnitudes, one quotient bit per cycle.
module rsa_divider #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder
);

    localparam int CNT_W = $clog2(WIDTH);

    logic [WIDTH-1:0] quo_reg;
    logic [WIDTH-1:0] quo_next;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] rem_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[WIDTH-1]};
        diff      = trial - {1'b0, divisor};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(WIDTH - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = diff[WIDTH] ? trial[WIDTH-1:0] : diff[WIDTH-1:0];
            quo_next = {quo_reg[WIDTH-2:0], ~diff[WIDTH]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> sv/rsa_datapath.sv
// Datapath: shared multiplier, range checks, divider, Euclid registers, quotient signs and accumulator.
module rsa_datapath
    import rsa_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rsa_cmd_t                   cmd,
    output rsa_sts_t                   sts,
    input  logic signed [FIELD_W-1:0]  numerator,
    input  logic signed [FIELD_W-1:0]  denominator,
    input  logic                       last,
    output logic signed [FIELD_W-1:0]  sum_numerator,
    output logic signed [FIELD_W-1:0]  sum_denominator,
    output logic [STATUS_W-1:0]        status
);

    localparam int DW = DATA_WIDTH;

    logic signed [DW-1:0]   n_reg;
    logic signed [DW-1:0]   d_reg;
    logic                   last_reg;
    logic signed [DW-1:0]   acc_num_reg;
    logic signed [DW-1:0]   acc_den_reg;
    logic [STATUS_W-1:0]    sticky_reg;
    logic signed [2*DW-1:0] p1_reg;
    logic signed [2*DW-1:0] p2_reg;
    logic signed [2*DW-1:0] pd_prod_reg;
    logic signed [DW-1:0]   pn_reg;
    logic signed [DW-1:0]   pd_reg;
    logic [DW-1:0]          x_mag_reg;
    logic [DW-1:0]          y_mag_reg;
    logic                   parity_reg;
    logic [DW-1:0]          qn_mag_reg;
    logic [DW-1:0]          qd_mag_reg;
    logic signed [DW-1:0]   out_num_reg;
    logic signed [DW-1:0]   out_den_reg;
    logic [STATUS_W-1:0]    out_status_reg;

    logic signed [DW-1:0]   mul_a;
    logic signed [DW-1:0]   mul_b;
    logic signed [2*DW-1:0] prod;
    logic signed [DW-1:0]   p1_lo;
    logic signed [DW-1:0]   p2_lo;
    logic signed [DW:0]     pn_wide;
    logic                   pn_ovf;
    logic                   pn_neg;
    logic                   pd_neg;
    logic                   g_neg;
    logic                   qn_neg;
    logic                   qd_neg;
    logic [DW-1:0]          pn_mag;
    logic [DW-1:0]          pd_mag;
    logic [DW-1:0]          qn_val;
    logic [DW-1:0]          qd_val;
    logic [DW-1:0]          div_dividend;
    logic [DW-1:0]          div_divisor;
    logic [DW-1:0]          div_quo;
    logic [DW-1:0]          div_rem;
    logic                   div_busy;
    logic                   div_done;

    function automatic logic fits(input logic signed [2*DW-1:0] v);
        return (v[2*DW-1:DW-1] == '0) || (v[2*DW-1:DW-1] == '1);
    endfunction

    function automatic logic [DW-1:0] abs_mag(input logic [DW-1:0] v);
        return v[DW-1] ? (~v + 1'b1) : v;
    endfunction

    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_AD:
            begin
                mul_a = acc_num_reg;
                mul_b = d_reg;
            end
            MUL_BN:
            begin
                mul_a = acc_den_reg;
                mul_b = n_reg;
            end
            MUL_BD:
            begin
                mul_a = acc_den_reg;
                mul_b = d_reg;
            end
            default:
            begin
                mul_a = acc_den_reg;
                mul_b = d_reg;
            end
        endcase
    end

    assign prod    = mul_a * mul_b;
    assign p1_lo   = p1_reg[DW-1:0];
    assign p2_lo   = p2_reg[DW-1:0];
    assign pn_wide = (DW+1)'(p1_lo) + (DW+1)'(p2_lo);
    assign pn_ovf  = pn_wide[DW] != pn_wide[DW-1];

    assign pn_neg = pn_reg[DW-1];
    assign pd_neg = pd_reg[DW-1];
    assign pn_mag = abs_mag(pn_reg);
    assign pd_mag = abs_mag(pd_reg);

    // Euclid's remainders alternate in sign between the two raw operands.
    assign g_neg  = parity_reg ? pd_neg : pn_neg;
    assign qn_neg = pn_neg ^ g_neg;
    assign qd_neg = pd_neg ^ g_neg;
    assign qn_val = qn_neg ? (~qn_mag_reg + 1'b1) : qn_mag_reg;
    assign qd_val = qd_neg ? (~qd_mag_reg + 1'b1) : qd_mag_reg;

    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_GCD:
            begin
                div_dividend = x_mag_reg;
                div_divisor  = y_mag_reg;
            end
            DIV_QN:
            begin
                div_dividend = pn_mag;
                div_divisor  = x_mag_reg;
            end
            DIV_QD:
            begin
                div_dividend = pd_mag;
                div_divisor  = x_mag_reg;
            end
            default:
            begin
                div_dividend = pd_mag;
                div_divisor  = x_mag_reg;
            end
        endcase
    end

    rsa_divider #(
        .WIDTH(DW)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo),
        .remainder(div_rem)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg    <= numerator[DW-1:0];
            d_reg    <= denominator[DW-1:0];
            last_reg <= last;
        end
        if (cmd.mul_en)
        begin
            unique case (cmd.mul_sel)
                MUL_AD:  p1_reg      <= prod;
                MUL_BN:  p2_reg      <= prod;
                MUL_BD:  pd_prod_reg <= prod;
                default: pd_prod_reg <= prod;
            endcase
        end
        if (cmd.sum_en)
        begin
            pn_reg     <= pn_wide[DW-1:0];
            pd_reg     <= pd_prod_reg[DW-1:0];
            x_mag_reg  <= abs_mag(pn_wide[DW-1:0]);
            y_mag_reg  <= abs_mag(pd_prod_reg[DW-1:0]);
            parity_reg <= 1'b0;
        end
        else if (cmd.gcd_step)
        begin
            x_mag_reg  <= y_mag_reg;
            y_mag_reg  <= div_rem;
            parity_reg <= ~parity_reg;
        end
        if (cmd.qn_en)
        begin
            qn_mag_reg <= div_quo;
        end
        if (cmd.qd_en)
        begin
            qd_mag_reg <= div_quo;
        end
        if (cmd.emit)
        begin
            out_num_reg    <= acc_num_reg;
            out_den_reg    <= acc_den_reg;
            out_status_reg <= sticky_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_num_reg <= '0;
            acc_den_reg <= DW'(1);
            sticky_reg  <= STATUS_OK;
        end
        else if (cmd.emit)
        begin
            acc_num_reg <= '0;
            acc_den_reg <= DW'(1);
            sticky_reg  <= STATUS_OK;
        end
        else
        begin
            if (cmd.set_raw)
            begin
                acc_num_reg <= pn_reg;
                acc_den_reg <= pd_reg;
            end
            else if (cmd.set_quot)
            begin
                acc_num_reg <= qn_val;
                acc_den_reg <= qd_val;
            end
            if (cmd.flag_en && (sticky_reg == STATUS_OK))
            begin
                sticky_reg <= cmd.flag_code;
            end
        end
    end

    always_comb
    begin
        sts.prod_ovf = !fits(p1_reg) || !fits(p2_reg) || !fits(pd_prod_reg) || pn_ovf;
        sts.y_zero   = y_mag_reg == '0;
        sts.g_zero   = x_mag_reg == '0;
        sts.quot_ovf = (!qn_neg && qn_mag_reg[DW-1]) || (!qd_neg && qd_mag_reg[DW-1]);
        sts.div_busy = div_busy;
        sts.div_done = div_done;
        sts.last     = last_reg;
    end

    assign sum_numerator   = FIELD_W'(out_num_reg);
    assign sum_denominator = FIELD_W'(out_den_reg);
    assign status          = out_status_reg;

endmodule

>>> sv/rsa_ctrl.sv
// Controller state machine sequencing multiply, check, Euclid loop, reduction and output.
module rsa_ctrl
    import rsa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output rsa_cmd_t cmd,
    input  rsa_sts_t sts
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_MUL_AD   = 4'd1;
    localparam logic [3:0] ST_MUL_BN   = 4'd2;
    localparam logic [3:0] ST_MUL_BD   = 4'd3;
    localparam logic [3:0] ST_SUM      = 4'd4;
    localparam logic [3:0] ST_GCD_TEST = 4'd5;
    localparam logic [3:0] ST_GCD_WAIT = 4'd6;
    localparam logic [3:0] ST_QN_START = 4'd7;
    localparam logic [3:0] ST_QN_WAIT  = 4'd8;
    localparam logic [3:0] ST_QD_START = 4'd9;
    localparam logic [3:0] ST_QD_WAIT  = 4'd10;
    localparam logic [3:0] ST_UPDATE   = 4'd11;
    localparam logic [3:0] ST_FINISH   = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL_AD;
                end
            end
            ST_MUL_AD:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_AD;
                state_next  = ST_MUL_BN;
            end
            ST_MUL_BN:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_BN;
                state_next  = ST_MUL_BD;
            end
            ST_MUL_BD:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_BD;
                state_next  = ST_SUM;
            end
            ST_SUM:
            begin
                if (sts.prod_ovf)
                begin
                    cmd.flag_en   = 1'b1;
                    cmd.flag_code = STATUS_OVERFLOW;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    cmd.sum_en = 1'b1;
                    state_next = ST_GCD_TEST;
                end
            end
            ST_GCD_TEST:
            begin
                cmd.div_sel = DIV_GCD;
                if (!sts.y_zero)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_GCD_WAIT;
                end
                else if (sts.g_zero)
                begin
                    cmd.flag_en   = 1'b1;
                    cmd.flag_code = STATUS_ZERO_DIV;
                    cmd.set_raw   = 1'b1;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    state_next = ST_QN_START;
                end
            end
            ST_GCD_WAIT:
            begin
                cmd.div_sel = DIV_GCD;
                if (sts.div_done)
                begin
                    cmd.gcd_step = 1'b1;
                    state_next   = ST_GCD_TEST;
                end
            end
            ST_QN_START:
            begin
                cmd.div_sel   = DIV_QN;
                cmd.div_start = 1'b1;
                state_next    = ST_QN_WAIT;
            end
            ST_QN_WAIT:
            begin
                cmd.div_sel = DIV_QN;
                if (sts.div_done)
                begin
                    cmd.qn_en  = 1'b1;
                    state_next = ST_QD_START;
                end
            end
            ST_QD_START:
            begin
                cmd.div_sel   = DIV_QD;
                cmd.div_start = 1'b1;
                state_next    = ST_QD_WAIT;
            end
            ST_QD_WAIT:
            begin
                cmd.div_sel = DIV_QD;
                if (sts.div_done)
                begin
                    cmd.qd_en  = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (sts.quot_ovf)
                begin
                    cmd.flag_en   = 1'b1;
                    cmd.flag_code = STATUS_OVERFLOW;
                end
                else
                begin
                    cmd.set_quot = 1'b1;
                end
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!sts.last)
                begin
                    state_next = ST_IDLE;
                end
                else if (!out_valid_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTH
    // A new result never overwrites one that has not been transferred.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending transfer");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !sts.div_busy)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> $past(sts.div_busy))
        else $error("divider done without a running division");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_MUL_AD))
        else $error("accepted fraction did not start the multiply sequence");
`endif

endmodule

>>> test/rational_sum_accumulator_unit_test.sv
// Self-checking testbench for the rational sum accumulator with its own fraction-sum predictor.
`timescale 1ns / 100ps

module rational_sum_accumulator_unit_test
    import rsa_pkg::*;
();

    localparam int WIDTH         = 32;
    localparam int RANDOM_ITEMS  = 1900;
    localparam int IDLE_LIMIT    = 20000;
    localparam int DRAIN_CYCLES  = 2000;
    localparam int PLAN_ROWS     = 24;

    localparam logic signed [FIELD_W-1:0] MAXV = 32'sh7FFF_FFFF;
    localparam logic signed [FIELD_W-1:0] MINV = 32'sh8000_0000;

    typedef struct packed {
        logic signed [FIELD_W-1:0] num;
        logic signed [FIELD_W-1:0] den;
        logic                      last;
        logic                      has_want;
        logic signed [FIELD_W-1:0] want_num;
        logic signed [FIELD_W-1:0] want_den;
        logic [STATUS_W-1:0]       want_status;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;

    rsa_stream_if #(.payload_t(rsa_in_t))  fraction_ch ();
    rsa_stream_if #(.payload_t(rsa_out_t)) result_ch ();

    rational_sum_accumulator_unit #(
        .DATA_WIDTH(WIDTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .fraction (fraction_ch),
        .result   (result_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    longint              run_num;
    longint              run_den;
    logic [STATUS_W-1:0] run_flags;
    rsa_out_t            sums_due[$];
    rsa_out_t            due_sum;
    int unsigned         errors;
    int unsigned         idle_cycles;
    int unsigned         rx_cycle;
    int unsigned         hold_left;
    int unsigned         burst_left;

    plan_row_t opening_plan [PLAN_ROWS] = '{
        '{32'sd0, 32'sd1, 1'b1, 1'b1, 32'sd0, 32'sd1, STATUS_OK},
        '{32'sd3, 32'sd6, 1'b1, 1'b1, 32'sd1, 32'sd2, STATUS_OK},
        '{-32'sd3, 32'sd6, 1'b1, 1'b1, 32'sd1, -32'sd2, STATUS_OK},
        '{32'sd0, 32'sd0, 1'b1, 1'b1, 32'sd0, 32'sd0, STATUS_ZERO_DIV},
        '{32'sd5, 32'sd0, 1'b1, 1'b1, 32'sd1, 32'sd0, STATUS_OK},
        '{MINV, -32'sd1, 1'b1, 1'b1, 32'sd0, 32'sd1, STATUS_OVERFLOW},
        '{MAXV, 32'sd1, 1'b0, 1'b0, 32'sd0, 32'sd0, STATUS_OK},
        '{32'sd1, 32'sd1, 1'b1, 1'b1, MAXV, 32'sd1, STATUS_OVERFLOW},
        '{MAXV, 32'sd1, 1'b0, 1'b0, 32'sd0, 32'sd0, STATUS_OK},
        '{32'sd1, 32'sd1, 1'b0, 1'b0, 32'sd0, 32'sd0, STATUS_OK},
        '{32'sd0, 32'sd0, 1'b0, 1'b0, 32'sd0, 32'sd0, STATUS_OK},
        '{32'sd7, 32'sd3, 1'b1, 1'b1, 32'sd0, 32'sd0, STATUS_OVERFLOW},
        '{MINV, MINV, 1'b1, 1'b1, 32'sd1, 32'sd1, STATUS_OK},
        '{MAXV, MINV, 1'b1, 1'b1, 32'sd0, 32'sd1, STATUS_OVERFLOW},
        '{32'sd1, 32'sd2, 1'b0, 1'b0, 32'sd0, 32'sd0, STATUS_OK},
        '{32'sd1, 32'sd3, 1'b1, 1'b0, 32'sd0, 32'sd0, STATUS_OK},
        '{-32'sd7, 32'sd4, 1'b0, 1'b0, 32'sd0, 32'sd0, STATUS_OK},
        '{32'sd3, -32'sd10, 1'b1, 1'b0, 32'sd0, 32'sd0, STATUS_OK},
        '{-32'sd1, -32'sd1, 1'b1, 1'b0, 32'sd0, 32'sd0, STATUS_OK},
        '{32'sd1, MAXV, 1'b0, 1'b0, 32'sd0, 32'sd0, STATUS_OK},
        '{32'sd1, MAXV, 1'b1, 1'b0, 32'sd0, 32'sd0, STATUS_OK},
        '{32'sh5555_5555, 32'shAAAA_AAAA, 1'b0, 1'b0, 32'sd0, 32'sd0, STATUS_OK},
        '{32'shAAAA_AAAA, 32'sh5555_5555, 1'b1, 1'b0, 32'sd0, 32'sd0, STATUS_OK},
        '{32'sd0, -32'sd5, 1'b1, 1'b1, 32'sd0, 32'sd1, STATUS_OK}
    };

    function automatic longint widen(input logic [FIELD_W-1:0] raw);
        logic signed [WIDTH-1:0] low;
        low = raw[WIDTH-1:0];
        return longint'(low);
    endfunction

    function automatic bit fits(input longint v);
        return v >= -(64'sd1 <<< (WIDTH - 1)) && v <= (64'sd1 <<< (WIDTH - 1)) - 1;
    endfunction

    function automatic void latch_status(input logic [STATUS_W-1:0] code);
        if (run_flags == STATUS_OK)
            run_flags = code;
    endfunction

    function automatic void clear_sum();
        run_num   = 0;
        run_den   = 1;
        run_flags = STATUS_OK;
    endfunction

    // Adds one fraction to the running sum; returns 1 when the fraction closes a sum.
    function automatic bit fold_fraction(input rsa_in_t f, output rsa_out_t total);
        longint n, d, p1, p2, pd, pn, x, y, r;
        n  = widen(f.numerator);
        d  = widen(f.denominator);
        p1 = run_num * d;
        p2 = run_den * n;
        pd = run_den * d;
        total = '0;
        if (!fits(p1) || !fits(p2) || !fits(pd))
            latch_status(STATUS_OVERFLOW);
        else
        begin
            pn = p1 + p2;
            if (!fits(pn))
                latch_status(STATUS_OVERFLOW);
            else
            begin
                x = pn;
                y = pd;
                while (y != 0)
                begin
                    r = x % y;
                    x = y;
                    y = r;
                end
                if (x == 0)
                begin
                    latch_status(STATUS_ZERO_DIV);
                    run_num = pn;
                    run_den = pd;
                end
                else if (!fits(pn / x) || !fits(pd / x))
                    latch_status(STATUS_OVERFLOW);
                else
                begin
                    run_num = pn / x;
                    run_den = pd / x;
                end
            end
        end
        if (!f.last)
            return 1'b0;
        total.sum_numerator   = run_num[FIELD_W-1:0];
        total.sum_denominator = run_den[FIELD_W-1:0];
        total.status          = run_flags;
        clear_sum();
        return 1'b1;
    endfunction

    function automatic logic signed [FIELD_W-1:0] draw_value(input bit for_den);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            if (!for_den)
                return $urandom_range(0, 40) - 20;
            if ($urandom_range(0, 24) == 0)
                return '0;
            return $urandom_range(0, 1) ? -$urandom_range(1, 24) : $urandom_range(1, 24);
        end
        if (pick < 80)
            return $urandom_range(0, 20000) - 10000;
        if (pick < 90)
            return $urandom();
        unique case ($urandom_range(0, 5))
            0: return MINV;
            1: return MAXV;
            2: return '0;
            3: return 32'sd1;
            4: return -32'sd1;
            default: return MINV + 32'sd1;
        endcase
    endfunction

    // Drives one fraction until it is taken, then books the sum that it closes.
    task automatic offer(input rsa_in_t item, input bit has_want, input rsa_out_t want);
        rsa_out_t total;
        fraction_ch.valid <= 1'b1;
        fraction_ch.data  <= item;
        @(posedge clk);
        while (!fraction_ch.ready)
            @(posedge clk);
        if (fold_fraction(item, total))
            sums_due.push_back(has_want ? want : total);
    endtask

    task automatic pace(input bit force_gap);
        int unsigned gap;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0 || force_gap)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 400)
                                              : $urandom_range(1, 8);
            fraction_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        rx_cycle++;
        unique case (rx_cycle[12:11])
            2'd0: result_ch.ready <= 1'b1;
            2'd1: result_ch.ready <= ($urandom_range(0, 3) != 0);
            2'd2:
            begin
                if (hold_left != 0)
                begin
                    hold_left--;
                    result_ch.ready <= 1'b0;
                end
                else
                begin
                    result_ch.ready <= 1'b1;
                    if ($urandom_range(0, 15) == 0)
                        hold_left = $urandom_range(1, 60);
                end
            end
            default: result_ch.ready <= rx_cycle[0];
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((fraction_ch.valid && fraction_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("rational_sum_accumulator_unit test failed");
                $finish;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (sums_due.size() == 0)
                begin
                    $display("%0t: unexpected result transfer %0d/%0d status %0d", $time,
                             result_ch.data.sum_numerator, result_ch.data.sum_denominator,
                             result_ch.data.status);
                    errors++;
                end
                else
                begin
                    due_sum = sums_due.pop_front();
                    if (result_ch.data.sum_numerator !== due_sum.sum_numerator)
                    begin
                        $display("%0t: sum_numerator expected %0d, got %0d", $time,
                                 due_sum.sum_numerator, result_ch.data.sum_numerator);
                        errors++;
                    end
                    if (result_ch.data.sum_denominator !== due_sum.sum_denominator)
                    begin
                        $display("%0t: sum_denominator expected %0d, got %0d", $time,
                                 due_sum.sum_denominator, result_ch.data.sum_denominator);
                        errors++;
                    end
                    if (result_ch.data.status !== due_sum.status)
                    begin
                        $display("%0t: status expected %0d, got %0d", $time,
                                 due_sum.status, result_ch.data.status);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        rsa_in_t     item;
        rsa_out_t    want;
        int unsigned sent;
        int unsigned span;
        bit          noisy;

        rst_n             = 1'b0;
        fraction_ch.valid = 1'b0;
        fraction_ch.data  = '0;
        result_ch.ready   = 1'b0;
        errors            = 0;
        idle_cycles       = 0;
        burst_left        = 0;
        clear_sum();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_plan[i])
        begin
            item.numerator   = opening_plan[i].num;
            item.denominator = opening_plan[i].den;
            item.last        = opening_plan[i].last;
            want.sum_numerator   = opening_plan[i].want_num;
            want.sum_denominator = opening_plan[i].want_den;
            want.status          = opening_plan[i].want_status;
            offer(item, opening_plan[i].has_want, want);
            pace(1'b0);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            noisy = ($urandom_range(0, 9) == 0);
            span  = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
            for (int k = 0; k < span; k++)
            begin
                if (noisy)
                begin
                    item.numerator   = $urandom();
                    item.denominator = $urandom();
                    item.last        = $urandom_range(0, 1);
                end
                else
                begin
                    item.numerator   = draw_value(1'b0);
                    item.denominator = draw_value(1'b1);
                    item.last        = (k == span - 1);
                end
                offer(item, 1'b0, '0);
                pace(1'b0);
                sent++;
            end
        end
        pace(1'b1);

        while (sums_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("rational_sum_accumulator_unit test passed");
        else
            $display("rational_sum_accumulator_unit test failed");
        $finish;
    end

endmodule
